>>> rtl/bhc_pkg.sv
// ---------------------------------------------------------------------------
// bhc_pkg
// Types, register codes and reset values shared by the bath heater controller.
// ---------------------------------------------------------------------------
`default_nettype none

package bhc_pkg;

   localparam int TempWidth   = 8;
   localparam int MinWidth    = 8;
   localparam int TimerWidth  = 12;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDatWidth = 12;

   localparam logic [TimerWidth-1:0] TimerMax = '1;

   // request codes
   localparam logic [1:0] ReqTick  = 2'd0;
   localparam logic [1:0] ReqShort = 2'd1;
   localparam logic [1:0] ReqLong  = 2'd2;

   // screen codes
   localparam logic [1:0] ScrHot   = 2'd0;
   localparam logic [1:0] ScrSteam = 2'd2;
   localparam logic [1:0] ScrMeter = 2'd3;

   // register indexes
   localparam logic [CsrIdxWidth-1:0] CsrLowTemp    = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CsrWarmTemp   = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CsrMaxHotTemp = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CsrHeatMin    = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CsrCheckSec   = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CsrMinuteSec  = 3'd5;

   // register reset values
   localparam logic signed [TempWidth-1:0] LowTempReset    = 8'sd3;
   localparam logic signed [TempWidth-1:0] WarmTempReset   = 8'sd10;
   localparam logic signed [TempWidth-1:0] MaxHotTempReset = 8'sd70;
   localparam logic [MinWidth-1:0]         HeatMinReset    = 8'd60;
   localparam logic [TimerWidth-1:0]       CheckSecReset   = 12'd300;
   localparam logic [TimerWidth-1:0]       MinuteSecReset  = 12'd60;

   typedef struct packed {
      logic [1:0]                  req_type;
      logic signed [TempWidth-1:0] cold_temp;
      logic                        cold_ok;
      logic signed [TempWidth-1:0] hot_temp;
      logic                        hot_ok;
   } req_type_type;

   typedef struct packed {
      logic                meter_heater_on;
      logic                water_heater_on;
      logic                alarm_pulse;
      logic [1:0]          screen;
      logic [MinWidth-1:0] minutes_left;
   } rsp_type;

   typedef struct packed {
      logic signed [TempWidth-1:0] low_temp;
      logic signed [TempWidth-1:0] warm_temp;
      logic signed [TempWidth-1:0] max_hot_temp;
      logic [MinWidth-1:0]         heat_minutes;
      logic [TimerWidth-1:0]       check_seconds;
      logic [TimerWidth-1:0]       minute_seconds;
   } cfg_type;

   typedef struct packed {
      logic [1:0]            screen_now;
      logic                  meter_heating;
      logic                  water_heating;
      logic [MinWidth-1:0]   minutes_count;
      logic [TimerWidth-1:0] check_timer;
      logic [TimerWidth-1:0] minute_timer;
   } state_type;

endpackage

`default_nettype wire

>>> rtl/bhc_channels.sv
// ---------------------------------------------------------------------------
// bhc channels
// Valid/ready channels carrying request and response items.
// ---------------------------------------------------------------------------
`default_nettype none

interface bhc_req_if
   import bhc_pkg::*;
();
   logic         valid;
   logic         ready;
   req_type_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface bhc_rsp_if
   import bhc_pkg::*;
();
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/bath_heater_controller_top.sv
// ---------------------------------------------------------------------------
// bath_heater_controller_top
// Frost heater, hot water timer and screen control for a bath heater.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries one item per tick or classified button press; rsp_chan
//   returns exactly one item per request with heater drives, alarm pulse,
//   screen and remaining minutes after that request.
//   A request accepted at a clock edge has its response registered and valid
//   in the cycle after. One item per cycle is sustained while rsp_chan.ready
//   stays high; the only path is the next-state logic between the state
//   registers and the response register.
//   req_chan.ready is high while the response register is empty or being
//   drained this cycle, so a stalled receiver holds one response and stops
//   further requests until it is taken.
//   csr_wr_en writes csr_wdata into register csr_index at the clock edge;
//   unknown indexes are dropped. The user must make writes while no item is
//   in flight; the block does not enforce this. Synchronous reset clears all
//   state, empties the response register and loads the register defaults.
// ---------------------------------------------------------------------------
`default_nettype none

module bath_heater_controller_top
   import bhc_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   bhc_req_if.sink               req_chan,
   bhc_rsp_if.source             rsp_chan,
   input  wire                   csr_wr_en,
   input  wire [CsrIdxWidth-1:0] csr_index,
   input  wire [CsrDatWidth-1:0] csr_wdata
);

   cfg_type   cfg_ff;
   state_type state_ff;
   state_type state_in;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic      rsp_valid_ff;
   logic      req_ready;
   logic      req_fire;

   assign req_ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire  = req_chan.valid && req_ready;

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   bhc_step u_step (
      .req (req_chan.payload),
      .cfg (cfg_ff),
      .cur (state_ff),
      .nxt (state_in),
      .rsp (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_temp       <= LowTempReset;
         cfg_ff.warm_temp      <= WarmTempReset;
         cfg_ff.max_hot_temp   <= MaxHotTempReset;
         cfg_ff.heat_minutes   <= HeatMinReset;
         cfg_ff.check_seconds  <= CheckSecReset;
         cfg_ff.minute_seconds <= MinuteSecReset;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CsrLowTemp:    cfg_ff.low_temp       <= csr_wdata[TempWidth-1:0];
            CsrWarmTemp:   cfg_ff.warm_temp      <= csr_wdata[TempWidth-1:0];
            CsrMaxHotTemp: cfg_ff.max_hot_temp   <= csr_wdata[TempWidth-1:0];
            CsrHeatMin:    cfg_ff.heat_minutes   <= csr_wdata[MinWidth-1:0];
            CsrCheckSec:   cfg_ff.check_seconds  <= csr_wdata[TimerWidth-1:0];
            CsrMinuteSec:  cfg_ff.minute_seconds <= csr_wdata[TimerWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            state_ff <= state_in;
         end
         if (req_ready) begin
            rsp_valid_ff <= req_chan.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef NO_ASSERTIONS
   // the water heater never runs with an empty count
   a_heat_needs_minutes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.water_heater_on |-> rsp_ff.minutes_left != '0)
      else $error("water heater on with zero minutes");

   // an alarm always comes with the meter screen and the meter heater on
   a_alarm_meter: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.alarm_pulse |->
         rsp_ff.screen == ScrMeter && rsp_ff.meter_heater_on)
      else $error("alarm without meter screen and heater");

   // a short press never raises the alarm and never lands on the meter screen
   a_press_no_alarm: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_chan.payload.req_type == ReqShort |=>
         rsp_valid_ff && !rsp_ff.alarm_pulse && rsp_ff.screen != ScrMeter)
      else $error("short press produced alarm or meter screen");

   // an accepted request always shows up as a response in the next cycle
   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted item has no response");
`endif

endmodule

`default_nettype wire

>>> rtl/bhc_step.sv
// ---------------------------------------------------------------------------
// bhc_step
// Next-state and response logic for one request item.
// ---------------------------------------------------------------------------
`default_nettype none

module bhc_step
   import bhc_pkg::*;
(
   input  wire req_type_type req,
   input  wire cfg_type      cfg,
   input  wire state_type    cur,
   output state_type         nxt,
   output rsp_type           rsp
);

   logic signed [TempWidth-1:0] cold;
   logic signed [TempWidth-1:0] hot;
   logic [TimerWidth-1:0]       check_bump;
   logic [TimerWidth-1:0]       minute_bump;
   logic [MinWidth-1:0]         minutes_dec;
   logic                        alarm;

   // a failed sensor reads as -1
   assign cold = req.cold_ok ? req.cold_temp : '1;
   assign hot  = req.hot_ok  ? req.hot_temp  : '1;

   assign check_bump  = (cur.check_timer  == TimerMax) ? TimerMax
                                                       : cur.check_timer + 1'b1;
   assign minute_bump = (cur.minute_timer == TimerMax) ? TimerMax
                                                       : cur.minute_timer + 1'b1;
   assign minutes_dec = cur.minutes_count - 1'b1;

   always_comb begin
      nxt   = cur;
      alarm = 1'b0;
      case (req.req_type)
         ReqTick: begin
            nxt.check_timer = check_bump;
            if (check_bump >= cfg.check_seconds) begin
               nxt.check_timer = '0;
               if (cold < cfg.low_temp) begin
                  nxt.screen_now    = ScrMeter;
                  nxt.meter_heating = 1'b1;
                  alarm             = 1'b1;
               end else if (cold >= cfg.warm_temp) begin
                  nxt.meter_heating = 1'b0;
               end
            end
            nxt.minute_timer = minute_bump;
            if (minute_bump >= cfg.minute_seconds && cur.minutes_count != '0) begin
               nxt.minutes_count = minutes_dec;
               nxt.minute_timer  = '0;
               if (minutes_dec == '0 || hot >= cfg.max_hot_temp) begin
                  nxt.water_heating = 1'b0;
               end
            end
         end
         ReqShort: begin
            nxt.screen_now = (cur.screen_now >= ScrSteam) ? ScrHot
                                                          : cur.screen_now + 1'b1;
         end
         ReqLong: begin
            // long press only acts on the hot water screen
            if (cur.screen_now == ScrHot) begin
               if (cur.minutes_count == '0) begin
                  nxt.minutes_count = cfg.heat_minutes;
                  nxt.water_heating = (cfg.heat_minutes != '0);
               end else begin
                  nxt.minutes_count = '0;
                  nxt.water_heating = 1'b0;
               end
               nxt.minute_timer = '0;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp.meter_heater_on = nxt.meter_heating;
   assign rsp.water_heater_on = nxt.water_heating;
   assign rsp.alarm_pulse     = alarm;
   assign rsp.screen          = nxt.screen_now;
   assign rsp.minutes_left    = nxt.minutes_count;

endmodule

`default_nettype wire
